>>> sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants for the linear probing hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int FILL_W = 9;
  localparam logic [FILL_W-1:0] FILL_LIMIT_RESET = 9'd192;

  // slot marks
  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_LIVE  = 2'd1;
  localparam logic [1:0] MARK_TOMB  = 2'd2;

  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_GET    = 2'd1,
    FN_REMOVE = 2'd2,
    FN_CLEAR  = 2'd3
  } lpht_func_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_PROBE,
    ST_VWAIT,
    ST_FINISH
  } lpht_state_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] key_hash;
    logic [63:0] write_value;
  } lpht_in_t;

  typedef struct packed {
    logic        found;
    logic [63:0] read_value;
    logic        rejected;
  } lpht_out_t;

  typedef struct packed {
    logic start;
    logic step;
  } probe_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
    logic free;
    logic had_tomb;
  } probe_stat_t;

endpackage

>>> sv/linear_probe_hash_table_top.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top
// Open-addressing key/value table with linear probing and tombstones.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with in_data (func, key, key_hash,
//   write_value); one result per request leaves on out_valid/out_ready.
//   cfg_we writes fill_limit from cfg_wdata; write it only while idle.
//   The probe reads one slot per cycle through the key RAM read port,
//   and the result is then loaded into the output register; a get that
//   hits first waits for the value RAM read. The next request can be
//   accepted once the result is loaded. Inserts refused by the fill
//   limit, clears, and gets and removes on an empty table skip the
//   probe. in_ready is low while a request is in flight.
//   After reset, and after each clear request, a clearing pass writes every
//   slot mark empty, one slot a cycle; in_ready stays low during it. The
//   clear result is offered as the pass starts.
//   A result sits in the output register until taken; a new request is
//   accepted meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = 256,
  parameter int KEY_BITS    = 64,
  parameter int VALUE_BITS  = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpht_in_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpht_out_t         out_data,
  input  logic              cfg_we,
  input  logic [FILL_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int KW_W  = KEY_BITS + 2;

  lpht_state_t state_r, state_nxt;

  logic [IDX_W-1:0]      sweep_cnt_r, sweep_cnt_nxt;
  logic [FILL_W-1:0]     used_r, used_nxt;
  logic [FILL_W-1:0]     fill_r;
  logic [1:0]            func_r, func_nxt;
  logic [KEY_BITS-1:0]   key_r, key_nxt;
  logic [VALUE_BITS-1:0] wval_r, wval_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic                  found_r, found_nxt;
  logic                  rej_r, rej_nxt;
  logic                  rdv_r, rdv_nxt;
  logic                  kwr_r, kwr_nxt;
  logic [1:0]            wr_mark_r, wr_mark_nxt;
  logic                  vwr_r, vwr_nxt;
  logic                  inc_r, inc_nxt;
  logic                  clr_r, clr_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lpht_out_t             out_data_r, out_data_nxt;

  logic                  accept, out_free, fire;
  probe_ctl_t            pctl;
  probe_stat_t           pstat;
  logic [IDX_W-1:0]      p_slot, k_raddr;
  logic [KW_W-1:0]       k_rdata, k_wdata;
  logic                  k_we;
  logic [IDX_W-1:0]      k_waddr;
  logic [VALUE_BITS-1:0] v_rdata;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign fire      = (state_r == ST_FINISH) && out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  lpht_probe #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BITS    (KEY_BITS)
  ) u_probe (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pctl),
    .start_idx (in_data.key_hash[IDX_W-1:0]),
    .key       (key_r),
    .rd_mark   (k_rdata[KW_W-1 -: 2]),
    .rd_key    (k_rdata[KEY_BITS-1:0]),
    .rd_addr   (k_raddr),
    .stat      (pstat),
    .slot      (p_slot)
  );

  // mark and key share one word
  always_comb begin
    if (state_r == ST_SWEEP) begin
      k_we    = 1'b1;
      k_waddr = sweep_cnt_r;
      k_wdata = {MARK_EMPTY, {KEY_BITS{1'b0}}};
    end else begin
      k_we    = fire && kwr_r;
      k_waddr = slot_r;
      k_wdata = {wr_mark_r, key_r};
    end
  end

  lpht_ram #(
    .WIDTH (KW_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  lpht_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (TABLE_SLOTS)
  ) u_val_ram (
    .clk   (clk),
    .we    (fire && vwr_r),
    .waddr (slot_r),
    .wdata (wval_r),
    .raddr (slot_r),
    .rdata (v_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    sweep_cnt_nxt = sweep_cnt_r;
    used_nxt      = used_r;
    func_nxt      = func_r;
    key_nxt       = key_r;
    wval_nxt      = wval_r;
    slot_nxt      = slot_r;
    found_nxt     = found_r;
    rej_nxt       = rej_r;
    rdv_nxt       = rdv_r;
    kwr_nxt       = kwr_r;
    wr_mark_nxt   = wr_mark_r;
    vwr_nxt       = vwr_r;
    inc_nxt       = inc_r;
    clr_nxt       = clr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pctl          = '0;

    unique case (state_r)
      ST_SWEEP: begin
        sweep_cnt_nxt = IDX_W'(sweep_cnt_r + 1'b1);
        if (sweep_cnt_r == {IDX_W{1'b1}}) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          func_nxt  = in_data.func;
          key_nxt   = in_data.key[KEY_BITS-1:0];
          wval_nxt  = in_data.write_value[VALUE_BITS-1:0];
          found_nxt = 1'b0;
          rej_nxt   = 1'b0;
          rdv_nxt   = 1'b0;
          kwr_nxt   = 1'b0;
          vwr_nxt   = 1'b0;
          inc_nxt   = 1'b0;
          clr_nxt   = 1'b0;
          state_nxt = ST_FINISH;
          priority if (in_data.func == FN_CLEAR) begin
            clr_nxt = 1'b1;
          end else if (in_data.func == FN_INSERT &&
                       ({1'b0, used_r} + 10'd1) > {1'b0, fill_r}) begin
            rej_nxt = 1'b1;
          end else if (in_data.func != FN_INSERT && used_r == '0) begin
            // empty table: nothing to find
          end else begin
            pctl.start = 1'b1;
            state_nxt  = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        pctl.step = 1'b1;
        if (pstat.done) begin
          slot_nxt  = p_slot;
          state_nxt = ST_FINISH;
          unique case (lpht_func_t'(func_r))
            FN_INSERT: begin
              if (pstat.hit || pstat.free) begin
                found_nxt   = pstat.hit;
                kwr_nxt     = 1'b1;
                vwr_nxt     = 1'b1;
                wr_mark_nxt = MARK_LIVE;
                inc_nxt     = pstat.free && !pstat.had_tomb;
              end else begin
                rej_nxt = 1'b1;
              end
            end
            FN_GET: begin
              if (pstat.hit) begin
                found_nxt = 1'b1;
                rdv_nxt   = 1'b1;
                state_nxt = ST_VWAIT;
              end
            end
            FN_REMOVE: begin
              if (pstat.hit) begin
                found_nxt   = 1'b1;
                kwr_nxt     = 1'b1;
                wr_mark_nxt = MARK_TOMB;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_VWAIT: begin
        // value RAM read of slot_r lands next cycle
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.found      = found_r;
          out_data_nxt.rejected   = rej_r;
          out_data_nxt.read_value = rdv_r ? 64'(v_rdata) : 64'd0;
          if (inc_r) begin
            used_nxt = FILL_W'(used_r + 1'b1);
          end
          if (clr_r) begin
            used_nxt      = '0;
            sweep_cnt_nxt = '0;
            state_nxt     = ST_SWEEP;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    key_r      <= key_nxt;
    wval_r     <= wval_nxt;
    slot_r     <= slot_nxt;
    found_r    <= found_nxt;
    rej_r      <= rej_nxt;
    rdv_r      <= rdv_nxt;
    kwr_r      <= kwr_nxt;
    wr_mark_r  <= wr_mark_nxt;
    vwr_r      <= vwr_nxt;
    inc_r      <= inc_nxt;
    clr_r      <= clr_nxt;
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      sweep_cnt_r <= '0;
      used_r      <= '0;
      fill_r      <= FILL_LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_cnt_r <= sweep_cnt_nxt;
      used_r      <= used_nxt;
      fill_r      <= cfg_we ? cfg_wdata : fill_r;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lpht_probe.sv
// ----------------------------------------------------------------------------
// lpht_probe
// Probe unit: walks the slot RAM one slot per cycle, compares keys and
// tracks the last tombstone passed.
// ----------------------------------------------------------------------------
module lpht_probe
  import lpht_pkg::*;
#(
  parameter int TABLE_SLOTS = 256,
  parameter int KEY_BITS    = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  probe_ctl_t                     ctl,
  input  logic [$clog2(TABLE_SLOTS)-1:0] start_idx,
  input  logic [KEY_BITS-1:0]            key,
  input  logic [1:0]                     rd_mark,
  input  logic [KEY_BITS-1:0]            rd_key,
  output logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
  output probe_stat_t                    stat,
  output logic [$clog2(TABLE_SLOTS)-1:0] slot
);

  localparam int IDX_W = $clog2(TABLE_SLOTS);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;
  logic [IDX_W-1:0] tomb_r, tomb_nxt;
  logic             have_tomb_r, have_tomb_nxt;
  logic             last;

  assign last    = (cnt_r == {IDX_W{1'b1}});
  // read ahead to the next slot; a stale read is simply dropped
  assign rd_addr = ctl.start ? start_idx : IDX_W'(idx_r + 1'b1);

  always_comb begin
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    tomb_nxt      = tomb_r;
    have_tomb_nxt = have_tomb_r;
    stat          = '0;
    slot          = idx_r;
    if (ctl.start) begin
      idx_nxt       = start_idx;
      cnt_nxt       = '0;
      have_tomb_nxt = 1'b0;
    end else if (ctl.step) begin
      idx_nxt = IDX_W'(idx_r + 1'b1);
      cnt_nxt = IDX_W'(cnt_r + 1'b1);
      priority if (rd_mark == MARK_EMPTY) begin
        stat.done     = 1'b1;
        stat.free     = 1'b1;
        stat.had_tomb = have_tomb_r;
        slot          = have_tomb_r ? tomb_r : idx_r;
      end else if (rd_mark == MARK_TOMB) begin
        tomb_nxt      = idx_r;
        have_tomb_nxt = 1'b1;
        if (last) begin
          stat.done     = 1'b1;
          stat.free     = 1'b1;
          stat.had_tomb = 1'b1;
          slot          = idx_r;
        end
      end else if (rd_key == key) begin
        stat.done = 1'b1;
        stat.hit  = 1'b1;
      end else if (last) begin
        // wrapped all the way: fall back to the last tombstone, if any
        stat.done     = 1'b1;
        stat.free     = have_tomb_r;
        stat.had_tomb = have_tomb_r;
        slot          = tomb_r;
      end else begin
        // live slot with another key: advance
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    cnt_r  <= cnt_nxt;
    tomb_r <= tomb_nxt;
    if (!rst_n) begin
      have_tomb_r <= 1'b0;
    end else begin
      have_tomb_r <= have_tomb_nxt;
    end
  end

endmodule

>>> sv/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks for the hash table, bound to the top level.
// ----------------------------------------------------------------------------
module lpht_checker
  import lpht_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input lpht_out_t out_data
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset starts the clearing pass and drops any result
  a_reset_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready or valid right after reset");

  // one request in flight at a time
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready stayed high after accepting a request");

  a_rej_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.rejected && out_data.found))
    else $error("result both rejected and found");

  a_value_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_value != 64'd0 |-> out_data.found)
    else $error("read value without a hit");

endmodule

bind linear_probe_hash_table_top lpht_checker u_lpht_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/sv/linear_probe_hash_table_top_test.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_top_test
// Self-checking bench for the linear probing key/value table.
// A scoreboard mirrors the slot array, marks and used count, predicts one
// result per accepted request and checks every result in order. A directed
// sequence covers the corner cases; random phases then run clustered key
// pools under several fill limits with random stalls on both channels.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_top_test;
  import lpht_pkg::*;

  localparam int SLOTS = 256;
  localparam int SLOT_MASK = SLOTS - 1;
  localparam int POOL_MAX = 320;
  localparam int SETTLE_CYCLES = 300;

  typedef enum int {PR_NONE, PR_FREE, PR_MATCH} probe_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  lpht_in_t          in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  lpht_out_t         out_data;
  logic              cfg_we = 1'b0;
  logic [FILL_W-1:0] cfg_wdata = '0;

  // scoreboard copy of the table
  logic [63:0]       tbl_key [SLOTS];
  logic [63:0]       tbl_val [SLOTS];
  logic [1:0]        tbl_mark [SLOTS];
  int                used_slots = 0;
  logic [FILL_W-1:0] fill_lim = FILL_LIMIT_RESET;

  lpht_in_t  pending_reqs[$];
  lpht_out_t expected_results[$];
  lpht_out_t want_res;

  logic [63:0] pool_key [POOL_MAX];
  logic [31:0] pool_hash [POOL_MAX];

  bit req_taken = 1'b0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int err_cnt = 0;
  int func_cnt [4] = '{0, 0, 0, 0};
  int hit_cnt = 0;
  int refused_cnt = 0;
  int limit_writes = 0;

  linear_probe_hash_table_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic probe_res_t probe_table(logic [63:0] k, logic [31:0] h,
                                             output int slot);
    int idx;
    int tomb;
    bit have_tomb;
    idx = int'(h & SLOT_MASK);
    tomb = 0;
    have_tomb = 1'b0;
    slot = 0;
    for (int n = 0; n < SLOTS; n++) begin
      if (tbl_mark[idx] == MARK_EMPTY) begin
        slot = have_tomb ? tomb : idx;
        return PR_FREE;
      end
      if (tbl_mark[idx] == MARK_TOMB) begin
        tomb = idx;
        have_tomb = 1'b1;
      end else if (tbl_key[idx] == k) begin
        slot = idx;
        return PR_MATCH;
      end
      idx = (idx + 1) & SLOT_MASK;
    end
    // wrapped all the way round: fall back on the last tombstone
    if (have_tomb) begin
      slot = tomb;
      return PR_FREE;
    end
    return PR_NONE;
  endfunction

  function automatic lpht_out_t apply_request(lpht_in_t r);
    lpht_out_t res;
    probe_res_t pr;
    int slot;
    res = '0;
    func_cnt[r.func]++;
    case (r.func)
      FN_INSERT: begin
        // fill check comes first, so even an update is refused
        if (used_slots + 1 > int'(fill_lim)) begin
          res.rejected = 1'b1;
        end else begin
          pr = probe_table(r.key, r.key_hash, slot);
          if (pr == PR_NONE) begin
            res.rejected = 1'b1;
          end else begin
            if (pr == PR_MATCH) begin
              res.found = 1'b1;
            end else if (tbl_mark[slot] == MARK_EMPTY) begin
              used_slots++;
            end
            tbl_mark[slot] = MARK_LIVE;
            tbl_key[slot] = r.key;
            tbl_val[slot] = r.write_value;
          end
        end
      end
      FN_GET, FN_REMOVE: begin
        if (used_slots != 0) begin
          pr = probe_table(r.key, r.key_hash, slot);
          if (pr == PR_MATCH) begin
            res.found = 1'b1;
            if (r.func == FN_GET) begin
              res.read_value = tbl_val[slot];
            end else begin
              tbl_mark[slot] = MARK_TOMB;
              tbl_key[slot] = '0;
              tbl_val[slot] = '0;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) tbl_mark[i] = MARK_EMPTY;
        used_slots = 0;
      end
    endcase
    hit_cnt += res.found;
    refused_cnt += res.rejected;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s: got %h, expected %h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // scoreboard: predict on every accepted request, check every taken result
  always @(posedge clk) begin
    req_taken = rst_n && in_valid && in_ready;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) tbl_mark[i] = MARK_EMPTY;
      used_slots = 0;
      fill_lim = FILL_LIMIT_RESET;
    end else begin
      if (cfg_we) fill_lim = cfg_wdata;
      if (req_taken) expected_results.push_back(apply_request(in_data));
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no request outstanding", out_data.read_value, '0);
        end else begin
          want_res = expected_results.pop_front();
          if (out_data.found !== want_res.found)
            report_mismatch("found", out_data.found, want_res.found);
          if (out_data.read_value !== want_res.read_value)
            report_mismatch("read_value", out_data.read_value, want_res.read_value);
          if (out_data.rejected !== want_res.rejected)
            report_mismatch("rejected", out_data.rejected, want_res.rejected);
        end
      end
    end
  end

  // request driver: hold until accepted, then advance or idle
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_gen != hold_seen) begin
      hold_seen = hold_gen;
      hold_left = 300;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic push_req(lpht_func_t f, logic [63:0] k, logic [31:0] h,
                          logic [63:0] v);
    lpht_in_t r;
    r.func = f;
    r.key = k;
    r.key_hash = h;
    r.write_value = v;
    pending_reqs.push_back(r);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    // let a clearing pass or a long probe finish before touching the register
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_fill_limit(logic [FILL_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    limit_writes++;
  endtask

  // keys with start slots clustered in a window, so probes collide and wrap
  task automatic fresh_pool(int n, int spread);
    int base;
    base = $urandom_range(0, SLOT_MASK);
    for (int i = 0; i < n; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_hash[i] = $urandom;
      pool_hash[i][7:0] = 8'((base + $urandom_range(0, spread)) & SLOT_MASK);
    end
  endtask

  task automatic random_phase(int n, int pool_n);
    int pick;
    int r;
    lpht_in_t q;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, pool_n - 1);
      r = $urandom_range(0, 99);
      q.key = pool_key[pick];
      q.key_hash = pool_hash[pick];
      q.write_value = {$urandom, $urandom};
      if (r < 45) q.func = FN_INSERT;
      else if (r < 72) q.func = FN_GET;
      else if (r < 92) q.func = FN_REMOVE;
      else if (r < 93) q.func = FN_CLEAR;
      else begin
        // noise: unrelated key and hash
        q.func = lpht_func_t'($urandom_range(0, 2));
        q.key = {$urandom, $urandom};
        q.key_hash = $urandom;
      end
      pending_reqs.push_back(q);
    end
  endtask

  initial begin
    logic [63:0] ka;
    logic [63:0] kb;
    logic [63:0] kc;
    logic [31:0] hc;
    ka = 64'h0123_4567_89ab_cdef;
    kb = 64'hfedc_ba98_7654_3210;
    kc = 64'h5a5a_a5a5_0f0f_f0f0;
    hc = 32'h8000_0010;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 21;
    recv_idle_pct = 66;
    repeat (SETTLE_CYCLES) @(posedge clk);

    // directed corner cases at the reset fill limit, then at limits of 1 and 0
    push_req(FN_GET, ka, hc, '1);
    push_req(FN_REMOVE, ka, hc, '0);
    push_req(FN_INSERT, ka, hc, 64'h1111);
    push_req(FN_INSERT, ka, hc, 64'h2222);
    push_req(FN_GET, ka, hc, '0);
    push_req(FN_INSERT, kb, hc, 64'h3333);
    push_req(FN_GET, kb, hc, '0);
    push_req(FN_REMOVE, ka, hc, '0);
    push_req(FN_GET, ka, hc, '0);
    push_req(FN_GET, kb, hc, '0);
    push_req(FN_INSERT, kc, hc, 64'h4444);
    push_req(FN_REMOVE, ~kc, hc, '0);
    push_req(FN_INSERT, '1, '1, '1);
    push_req(FN_INSERT, '0, 32'h0000_00ff, '0);
    push_req(FN_GET, '0, 32'h0000_00ff, '1);
    push_req(FN_GET, '1, '1, '0);
    push_req(FN_CLEAR, '1, '1, '1);
    push_req(FN_GET, kb, hc, '0);
    wait_drained();
    set_fill_limit(9'd1);
    push_req(FN_INSERT, ka, hc, 64'h5555);
    push_req(FN_INSERT, kb, hc, 64'h6666);
    push_req(FN_INSERT, ka, hc, 64'h7777);
    wait_drained();
    set_fill_limit(9'd0);
    push_req(FN_INSERT, kb, hc, 64'h8888);
    push_req(FN_GET, ka, hc, '0);
    wait_drained();

    // clustered pool at the default limit; long receiver hold-off at its start
    set_fill_limit(FILL_LIMIT_RESET);
    push_req(FN_CLEAR, '0, '0, '0);
    fresh_pool(48, 20);
    random_phase(350, 48);
    hold_gen++;
    wait_drained();

    // fill the whole table past its size, then churn it
    send_idle_pct = 66;
    recv_idle_pct = 21;
    set_fill_limit(9'd511);
    push_req(FN_CLEAR, '0, '0, '0);
    fresh_pool(300, SLOT_MASK);
    for (int i = 0; i < 300; i++) begin
      push_req(FN_INSERT, pool_key[i], pool_hash[i], {$urandom, $urandom});
      if ($urandom_range(0, 9) == 0) begin
        push_req(FN_GET, pool_key[$urandom_range(0, i)], pool_hash[i], '0);
      end
    end
    random_phase(80, 300);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_fill_limit(9'd256);
    push_req(FN_CLEAR, '0, '0, '0);
    fresh_pool(64, 40);
    random_phase(300, 64);
    hold_gen++;
    wait_drained();

    // tight limit: many refused inserts
    set_fill_limit(9'($urandom_range(2, 16)));
    push_req(FN_CLEAR, '0, '0, '0);
    fresh_pool(24, 15);
    random_phase(200, 24);
    wait_drained();

    $display("Summary: %0d inserts, %0d gets, %0d removes, %0d clears; %0d hits,",
             func_cnt[FN_INSERT], func_cnt[FN_GET], func_cnt[FN_REMOVE],
             func_cnt[FN_CLEAR], hit_cnt);
    $display("  %0d refused inserts over %0d fill limit writes, %0d mismatches",
             refused_cnt, limit_writes, err_cnt);
    if (err_cnt == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout, %0d results still outstanding", expected_results.size());
    $display("FAIL");
    $finish;
  end

endmodule
